@@ rtl/core/lzsr_pkg.sv @@
// ----------------------------------------------------------------------------
// lzsr_pkg
// Shared widths for the longest zero-sum run finder: prefix sum, element
// value, result length and the epoch tag kept with each hash table entry.
// ----------------------------------------------------------------------------
package lzsr_pkg;

  // Width of one input element.
  localparam int VALUE_W = 32;
  // Width of the running prefix sum; wide enough that it never wraps.
  localparam int SUM_W   = 48;
  // Width of the reported run length.
  localparam int LEN_W   = 11;
  // Width of the epoch tag that marks which array wrote a table entry.
  localparam int EPOCH_W = 8;

endpackage

@@ rtl/core/lzsr_hash.sv @@
// ----------------------------------------------------------------------------
// lzsr_hash
// Folds a prefix sum into a hash table address by XOR of its bits, taken
// modulo the address width.
// ----------------------------------------------------------------------------
module lzsr_hash #(
  parameter int AW = 11
) (
  input  logic [lzsr_pkg::SUM_W-1:0] sum_i,
  output logic [AW-1:0]              addr_o
);
  import lzsr_pkg::*;

  // Each sum bit lands on address bit (i mod AW).
  always_comb begin
    logic [AW-1:0] fold;
    fold = '0;
    for (int i = 0; i < SUM_W; i++) begin
      fold[i % AW] = fold[i % AW] ^ sum_i[i];
    end
    addr_o = fold;
  end

endmodule

@@ rtl/core/lzsr_table.sv @@
// ----------------------------------------------------------------------------
// lzsr_table
// Hash table storage: a synchronous memory with one write port and one
// read port, with the read data registered.
// ----------------------------------------------------------------------------
module lzsr_table #(
  parameter int AW = 11,
  parameter int DW = 67
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);
  import lzsr_pkg::*;

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/longest_zero_sum_run.sv @@
// ----------------------------------------------------------------------------
// longest_zero_sum_run
// Streams array elements, keeps a prefix sum and a hash table of the first
// position of each prefix sum, and reports the longest zero-sum run.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one signed element per request, with last_i set on
// the final element of an array. The output channel carries one result per
// array, the longest zero-sum run length and an overflow flag, issued after
// the element marked last. Elements beyond MAX_ELEMS are dropped and flagged.
// An element inside capacity passes through S_HASH, S_READ and S_CHECK when
// its prefix sum hits the table on the first probe or lands in an empty slot;
// each further linear probe repeats S_READ and S_CHECK (one read of the single
// table memory and its check). The table holds 2 * 2**clog2(MAX_ELEMS)
// entries, at least twice MAX_ELEMS, so chains stay short. The last element
// of an array then passes through S_EMIT, which loads the result register.
// Entries carry an epoch tag, so starting a new array costs nothing; after
// reset and when the tag wraps after 255 arrays, every entry is cleared while
// in_stall_o stays high. A result waiting under out_stall_i does not block
// new elements; only the next result waits until the output register frees.
// ----------------------------------------------------------------------------
module longest_zero_sum_run #(
  parameter int MAX_ELEMS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [lzsr_pkg::VALUE_W-1:0] value_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lzsr_pkg::LEN_W-1:0]         longest_length_o,
  output logic                               overflow_o
);
  import lzsr_pkg::*;

  localparam int POS_W = $clog2(MAX_ELEMS + 1);
  localparam int AW    = $clog2(MAX_ELEMS) + 1;
  localparam int DW    = EPOCH_W + SUM_W + POS_W;

  // Controller states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   best_q, best_d;
  logic               ovf_q, ovf_d;
  logic               last_q, last_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               out_valid_q, out_valid_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  logic               out_ovf_q, out_ovf_d;

  logic               in_accept;
  logic               out_free;
  logic [AW-1:0]      hash_addr;
  logic               rd_en;
  logic [DW-1:0]      rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DW-1:0]      wr_data;
  logic [EPOCH_W-1:0] rd_epoch;
  logic [SUM_W-1:0]   rd_sum;
  logic [POS_W-1:0]   rd_pos;
  logic [POS_W-1:0]   run_len;

  lzsr_hash #(
    .AW(AW)
  ) u_hash (
    .sum_i (sum_q),
    .addr_o(hash_addr)
  );

  lzsr_table #(
    .AW(AW),
    .DW(DW)
  ) u_table (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(addr_q),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // Handshakes.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Split the entry read back from the table.
  assign rd_epoch = rd_data[DW-1 -: EPOCH_W];
  assign rd_sum   = rd_data[POS_W +: SUM_W];
  assign rd_pos   = rd_data[POS_W-1:0];
  assign run_len  = pos_q - rd_pos;

  // Table port control: clearing pass writes, or insert of a new sum.
  assign rd_en   = (state_q == S_READ);
  assign wr_en   = (state_q == S_CLEAR) ||
                   ((state_q == S_CHECK) && (rd_epoch != epoch_q));
  assign wr_addr = (state_q == S_CLEAR) ? clr_addr_q : addr_q;
  assign wr_data = (state_q == S_CLEAR) ? '0 : {epoch_q, sum_q, pos_q};

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    pos_d       = pos_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    addr_d      = addr_q;
    clr_addr_d  = clr_addr_q;
    epoch_d     = epoch_q;
    out_valid_d = out_valid_q;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;

    // The receiver takes the pending result.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          last_d = last_i;
          if (pos_q == POS_W'(MAX_ELEMS)) begin
            // Beyond capacity: drop the element, keep the flag.
            ovf_d   = 1'b1;
            state_d = last_i ? S_EMIT : S_IDLE;
          end else begin
            sum_d   = sum_q + {{(SUM_W - VALUE_W){value_i[VALUE_W-1]}}, value_i};
            pos_d   = pos_q + 1'b1;
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        // A zero prefix sum matches position 0 and never enters the table.
        if (sum_q == '0) begin
          if (pos_q > best_q) begin
            best_d = pos_q;
          end
          state_d = last_q ? S_EMIT : S_IDLE;
        end else begin
          addr_d  = hash_addr;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (rd_epoch == epoch_q) begin
          if (rd_sum == sum_q) begin
            // Repeated sum: the run since its first position sums to zero.
            if (run_len > best_q) begin
              best_d = run_len;
            end
            state_d = last_q ? S_EMIT : S_IDLE;
          end else begin
            // Occupied by another sum: probe the next slot.
            addr_d  = addr_q + 1'b1;
            state_d = S_READ;
          end
        end else begin
          // Free slot: the sum was inserted this cycle.
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_len_d   = LEN_W'(best_q);
          out_ovf_d   = ovf_q;
          sum_d       = '0;
          pos_d       = '0;
          best_d      = '0;
          ovf_d       = 1'b0;
          // Advance the epoch; on wrap, sweep the table first.
          if (epoch_q == '1) begin
            epoch_d    = EPOCH_W'(1);
            clr_addr_d = '0;
            state_d    = S_CLEAR;
          end else begin
            epoch_d = epoch_q + 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sum_q       <= '0;
      pos_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      clr_addr_q  <= '0;
      epoch_q     <= EPOCH_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      clr_addr_q  <= clr_addr_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign longest_length_o = out_len_q;
  assign overflow_o       = out_ovf_q;

endmodule
